// ----- src/sdln_pkg.sv -----
// Shared types, constants and tap table for the selectable-degree noise source.
package sdln_pkg;

    localparam int unsigned DEG_W   = 6;
    localparam int unsigned NOISE_W = 15;
    localparam int unsigned ACT_W   = 4;
    localparam int unsigned WORK_W  = NOISE_W + 1;

    localparam logic [ACT_W-1:0]   DEG_MIN      = 4'd2;
    localparam logic [ACT_W-1:0]   DEG_MAX      = 4'd15;
    localparam logic [NOISE_W-1:0] SHIFT_RESET  = 15'd3;
    localparam logic [ACT_W-1:0]   ACTIVE_RESET = 4'd2;

    // Result of one register step
    typedef struct packed {
        logic [NOISE_W-1:0] noise_word;
        logic [ACT_W-1:0]   degree;
    } t_step;

    // Feedback tap mask for each register length
    function automatic logic [WORK_W-1:0] tap_mask(input logic [ACT_W-1:0] deg);
        logic [WORK_W-1:0] m;
        case (deg)
            4'd5:    m = 16'h0005;
            4'd8:    m = 16'h001D;
            4'd9:    m = 16'h0011;
            4'd10:   m = 16'h0009;
            4'd11:   m = 16'h0005;
            4'd12:   m = 16'h0053;
            4'd13:   m = 16'h001B;
            4'd14:   m = 16'h0033;
            default: m = 16'h0003;
        endcase
        return m;
    endfunction

endpackage

// ----- src/sdln_deg_if.sv -----
// Request channel: one degree word per handshake.
interface sdln_deg_if;
    import sdln_pkg::*;

    logic             valid;
    logic             ready;
    logic [DEG_W-1:0] degree;

    modport source (output valid, output degree, input ready);
    modport sink   (input valid, input degree, output ready);
endinterface

// ----- src/sdln_noise_if.sv -----
// Result channel: one noise word per handshake.
interface sdln_noise_if;
    import sdln_pkg::*;

    logic               valid;
    logic               ready;
    logic [NOISE_W-1:0] noise_word;

    modport source (output valid, output noise_word, input ready);
    modport sink   (input valid, input noise_word, output ready);
endinterface

// ----- src/sdln_step.sv -----
// One step of the selectable-degree shift register: trim, feedback, shift.
module sdln_step
    import sdln_pkg::*;
(
    input  logic [DEG_W-1:0]   i_degree,
    input  logic [NOISE_W-1:0] i_shift,
    input  logic [ACT_W-1:0]   i_active,
    output t_step              o_next
);

    logic [ACT_W-1:0]  deg;
    logic [WORK_W-1:0] len_mask;
    logic [WORK_W-1:0] work;
    logic              fb;

    // Clamp degree to the legal range, out of range selects the longest
    always_comb begin
        if (i_degree >= DEG_W'(DEG_MIN) && i_degree <= DEG_W'(DEG_MAX)) begin
            deg = i_degree[ACT_W-1:0];
        end else begin
            deg = DEG_MAX;
        end
    end

    assign len_mask = (WORK_W'(1) << deg) - WORK_W'(1);

    // Trim on degree change, insert feedback at the top, shift right
    always_comb begin
        work = {1'b0, i_shift};
        if (deg != i_active) begin
            work = work & len_mask;
            if (work == '0) begin
                work = len_mask;
            end
        end
        fb = ^(work & tap_mask(deg));
        work[deg] = fb;
        o_next.noise_word = work[WORK_W-1:1];
        o_next.degree     = deg;
    end

endmodule

// ----- src/selectable_degree_lfsr_noise_top.sv -----
// Selectable-degree noise source top level: degree register, step logic, result register.
// An accepted degree word passes through the input register and then the result register to the output.
// Throughput: one word per cycle while o_noise.ready holds; the step is one parity tree and a shift.
// The register state advances when a degree word moves from the input register
// to the result register, so words are stepped strictly in arrival order.
// Reset (i_rst_n low, synchronous): both stages empty, register = 3, degree = 2.
module selectable_degree_lfsr_noise_top
    import sdln_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    sdln_deg_if.sink            i_deg,
    sdln_noise_if.source        o_noise
);

    logic               r_in_valid;
    logic [DEG_W-1:0]   r_in_degree;
    logic               r_out_valid;
    logic [NOISE_W-1:0] r_noise;
    logic [NOISE_W-1:0] r_shift_value;
    logic [ACT_W-1:0]   r_active_degree;

    logic  advance;
    logic  in_take;
    t_step step_next;

    // Move a word into the result register when it is empty or being drained
    assign advance = r_in_valid && (!r_out_valid || o_noise.ready);
    assign in_take = i_deg.valid && i_deg.ready;

    assign i_deg.ready        = !r_in_valid || advance;
    assign o_noise.valid      = r_out_valid;
    assign o_noise.noise_word = r_noise;

    sdln_step u_step (
        .i_degree (r_in_degree),
        .i_shift  (r_shift_value),
        .i_active (r_active_degree),
        .o_next   (step_next)
    );

    // Hold the incoming degree word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_deg.ready) begin
            r_in_valid <= in_take;
        end
        if (in_take) begin
            r_in_degree <= i_deg.degree;
        end
    end

    // Advance the register state and load the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_shift_value   <= SHIFT_RESET;
            r_active_degree <= ACTIVE_RESET;
        end else begin
            if (advance) begin
                r_out_valid     <= 1'b1;
                r_shift_value   <= step_next.noise_word;
                r_active_degree <= step_next.degree;
            end else if (o_noise.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_noise <= step_next.noise_word;
        end
    end

`ifndef SYNTHESIS
    // Active degree always stays in the legal range
    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active_degree >= DEG_MIN)
        else $error("active degree below minimum");

    // The register never locks up at zero
    a_shift_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift_value != '0)
        else $error("shift register reached zero");

    // A stepped word fits within the degree it was made for
    a_noise_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> ((r_noise >> r_active_degree) == '0))
        else $error("noise word exceeds active degree");

    // A stalled result is not overwritten before it is taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_noise.ready) |-> !advance)
        else $error("result overwritten while stalled");
`endif

endmodule
